>>> design/cdcp_pkg.sv
// ----------------------------------------------------------------------------
// cdcp_pkg: shared types and constants for cache-domain core placement
// Sizes of the core list and domain map, configuration register indexes,
// and the packed input and result items.
// ----------------------------------------------------------------------------
package cdcp_pkg;

  localparam int MAX_CORES    = 64;
  localparam int MAX_DOMAINS  = 64;
  localparam int RESULT_LIMIT = 64;

  localparam int CPU_W  = 12;
  localparam int DOM_W  = 6;
  localparam int IDX_W  = $clog2(MAX_CORES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int KEY_W  = DOM_W + IDX_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int PROD_W     = 2 * CFG_DATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PARTITIONS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_INDEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 2'd2;

  typedef struct packed {
    logic [CPU_W-1:0] core_cpu;
    logic [DOM_W-1:0] core_domain;
    logic             list_end;
  } core_item_t;

  typedef struct packed {
    logic [CPU_W-1:0] placed_cpu;
    logic             run_last;
    logic             failed;
  } place_result_t;

endpackage

>>> design/cache_domain_core_placement.sv
// ----------------------------------------------------------------------------
// cache_domain_core_placement: deal CPU ids of cores over shared-cache domains
// Loads a core list and hands out `partitions` CPU ids for one co-located
// group, or one failure result.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one core per transfer, taken when start is high and busy is low.
//   Cores load at one per cycle into the core RAM (overflow beyond the list
//   size is dropped). A core with list_end set starts placement; busy stays
//   high until the final result has been issued.
//   Configuration: cfg_we writes cfg_data to register cfg_index (partitions,
//   group index, group count) at once; write only while busy is low.
//   Output: each result shows on result for one cycle with result_strobe;
//   the receiver cannot stall. run_last marks the last result of a run, and
//   a failed run gives a single result with failed and run_last set.
//   Sequence: placement runs over the core RAM with one read per cycle:
//   setup (two multiplies and the arm choice); in the dealt arm only, a step
//   per chosen domain to build the domain map and a rank pass where each
//   core scans the cores before it; then one scan of the n stored cores per
//   ordered entry, up to offset + partitions entries. Reset: registers return
//   to partitions 1, group index 0, group count 1; the core list is empty and
//   no result is pending.
// ----------------------------------------------------------------------------
module cache_domain_core_placement (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  cdcp_pkg::core_item_t                core,
  input  logic                                cfg_we,
  input  logic [cdcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cdcp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                result_strobe,
  output cdcp_pkg::place_result_t             result
);

  import cdcp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_ARM,
    S_MASK,
    S_RANK_HEAD,
    S_RANK_LOAD,
    S_RANK_SCAN,
    S_LEN_CHECK,
    S_FIND,
    S_FAIL
  } state_t;

  state_t state;

  logic [CFG_DATA_W-1:0] partitions;
  logic [DOM_W-1:0]      grp_index;
  logic [CFG_DATA_W-1:0] grp_count;

  logic [CNT_W-1:0]       core_count;
  logic [DOM_W-1:0]       highest_domain;
  logic                   dealt;
  logic [MAX_DOMAINS-1:0] dom_mask;
  logic [DOM_W:0]         dom_cur;
  logic [PROD_W-1:0]      prod;
  logic [CNT_W-1:0]       order_len;
  logic [CNT_W-1:0]       i_cnt;
  logic [CNT_W-1:0]       j_cnt;
  logic                   pv;
  logic [IDX_W-1:0]       j_d;
  logic [DOM_W-1:0]       dom_i;
  logic [IDX_W-1:0]       rcnt;
  logic [CNT_W-1:0]       t_cnt;
  logic [CNT_W-1:0]       t_start;
  logic [CNT_W-1:0]       t_end;
  logic [KEY_W-1:0]       prev_key;
  logic                   have_prev;
  logic [KEY_W-1:0]       best_key;
  logic [CPU_W-1:0]       best_cpu;
  logic                   have_best;

  // load path
  logic             load;
  logic             store_ok;
  logic [DOM_W-1:0] dom_in;

  // shared multiplier
  logic [CFG_DATA_W-1:0] mul_a;
  logic [PROD_W-1:0]     mul_out;

  // RAM ports
  logic [IDX_W-1:0]       rd_addr;
  logic [CPU_W+DOM_W-1:0] core_rd;
  logic [IDX_W-1:0]       rank_rd;
  logic                   rank_we;

  // scan datapath
  logic             issue;
  logic [DOM_W-1:0] cand_dom;
  logic [CPU_W-1:0] cand_cpu;
  logic [KEY_W-1:0] cand_key;
  logic             cand_ok;
  logic             fail_early;
  logic             flat_fail;
  logic [CNT_W-1:0] flat_start;

  assign busy     = (state != S_IDLE);
  assign load     = start && !busy;
  assign store_ok = (core_count < CNT_W'(MAX_CORES));
  assign dom_in   = ({1'b0, core.core_domain} >= (DOM_W+1)'(MAX_DOMAINS)) ?
                    DOM_W'(MAX_DOMAINS - 1) : core.core_domain;

  cdcp_ram #(.WIDTH(CPU_W + DOM_W), .DEPTH(MAX_CORES)) u_core_ram (
    .clk   (clk),
    .we    (load && store_ok),
    .waddr (core_count[IDX_W-1:0]),
    .wdata ({dom_in, core.core_cpu}),
    .raddr (rd_addr),
    .rdata (core_rd)
  );

  cdcp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_CORES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (i_cnt[IDX_W-1:0]),
    .wdata (rcnt),
    .raddr (rd_addr),
    .rdata (rank_rd)
  );

  assign mul_a   = (state == S_MUL_A) ? grp_count : CFG_DATA_W'(grp_index);
  assign mul_out = PROD_W'(mul_a) * PROD_W'(partitions);

  assign rd_addr = (state == S_RANK_HEAD) ? i_cnt[IDX_W-1:0] : j_cnt[IDX_W-1:0];
  assign issue   = (state == S_RANK_SCAN) ? (j_cnt < i_cnt) : (j_cnt < core_count);
  assign rank_we = (state == S_RANK_SCAN) && !issue && !pv;

  assign cand_dom = core_rd[CPU_W +: DOM_W];
  assign cand_cpu = core_rd[CPU_W-1:0];
  // dealt order is depth-major then domain; flat order is domain then arrival
  assign cand_key = dealt ? {rank_rd, cand_dom} : {cand_dom, j_d};
  assign cand_ok  = pv && (!dealt || dom_mask[cand_dom]) &&
                    (!have_prev || (cand_key > prev_key)) &&
                    (!have_best || (cand_key < best_key));

  assign fail_early = (core_count == '0) || (grp_count == '0) ||
                      (partitions == '0) ||
                      (partitions > CFG_DATA_W'(RESULT_LIMIT)) ||
                      (prod > PROD_W'(core_count));
  assign flat_fail  = ((PROD_W+1)'(prod) + (PROD_W+1)'(partitions)) >
                      (PROD_W+1)'(core_count);
  assign flat_start = prod[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      partitions <= CFG_DATA_W'(1);
      grp_index  <= '0;
      grp_count  <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PARTITIONS:  partitions <= cfg_data;
        CFG_GROUP_INDEX: grp_index  <= cfg_data[DOM_W-1:0];
        CFG_GROUP_COUNT: grp_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      core_count     <= '0;
      highest_domain <= '0;
      result_strobe  <= 1'b0;
      pv             <= 1'b0;
      have_prev      <= 1'b0;
      have_best      <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (load) begin
            if (store_ok) begin
              core_count <= core_count + CNT_W'(1);
              if (dom_in > highest_domain) begin
                highest_domain <= dom_in;
              end
            end
            if (core.list_end) begin
              state <= S_MUL_A;
            end
          end
        end
        S_MUL_A: begin
          prod  <= mul_out;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          prod <= mul_out;
          if (fail_early) begin
            state <= S_FAIL;
          end else begin
            state <= S_ARM;
          end
        end
        S_ARM: begin
          if (grp_count <= CFG_DATA_W'(highest_domain) + CFG_DATA_W'(1)) begin
            dealt    <= 1'b1;
            dom_mask <= '0;
            dom_cur  <= {1'b0, grp_index};
            state    <= S_MASK;
          end else begin
            dealt <= 1'b0;
            if (flat_fail) begin
              state <= S_FAIL;
            end else begin
              t_start   <= flat_start;
              t_end     <= flat_start + CNT_W'(partitions);
              t_cnt     <= '0;
              j_cnt     <= '0;
              pv        <= 1'b0;
              have_prev <= 1'b0;
              have_best <= 1'b0;
              state     <= S_FIND;
            end
          end
        end
        S_MASK: begin
          // step through the domains of this group, one per cycle
          if (dom_cur <= {1'b0, highest_domain}) begin
            dom_mask[dom_cur[DOM_W-1:0]] <= 1'b1;
            dom_cur <= dom_cur + (DOM_W+1)'(grp_count);
          end else begin
            i_cnt     <= '0;
            order_len <= '0;
            state     <= S_RANK_HEAD;
          end
        end
        S_RANK_HEAD: begin
          state <= S_RANK_LOAD;
        end
        S_RANK_LOAD: begin
          dom_i <= cand_dom;
          if (dom_mask[cand_dom]) begin
            order_len <= order_len + CNT_W'(1);
          end
          rcnt  <= '0;
          j_cnt <= '0;
          pv    <= 1'b0;
          state <= S_RANK_SCAN;
        end
        S_RANK_SCAN: begin
          // count earlier cores of the same domain
          pv <= issue;
          if (issue) begin
            j_cnt <= j_cnt + CNT_W'(1);
          end
          if (pv && (cand_dom == dom_i)) begin
            rcnt <= rcnt + IDX_W'(1);
          end
          if (!issue && !pv) begin
            i_cnt <= i_cnt + CNT_W'(1);
            if (i_cnt + CNT_W'(1) == core_count) begin
              state <= S_LEN_CHECK;
            end else begin
              state <= S_RANK_HEAD;
            end
          end
        end
        S_LEN_CHECK: begin
          if (order_len < CNT_W'(partitions)) begin
            state <= S_FAIL;
          end else begin
            t_start   <= '0;
            t_end     <= CNT_W'(partitions);
            t_cnt     <= '0;
            j_cnt     <= '0;
            pv        <= 1'b0;
            have_prev <= 1'b0;
            have_best <= 1'b0;
            state     <= S_FIND;
          end
        end
        S_FIND: begin
          // one pass finds the smallest key above the previous one
          pv <= issue;
          if (issue) begin
            j_cnt <= j_cnt + CNT_W'(1);
            j_d   <= j_cnt[IDX_W-1:0];
          end
          if (cand_ok) begin
            best_key  <= cand_key;
            best_cpu  <= cand_cpu;
            have_best <= 1'b1;
          end
          if (!issue && !pv) begin
            prev_key  <= best_key;
            have_prev <= 1'b1;
            have_best <= 1'b0;
            j_cnt     <= '0;
            t_cnt     <= t_cnt + CNT_W'(1);
            if (t_cnt >= t_start) begin
              result_strobe     <= 1'b1;
              result.placed_cpu <= best_cpu;
              result.run_last   <= (t_cnt + CNT_W'(1) == t_end);
              result.failed     <= 1'b0;
            end
            if (t_cnt + CNT_W'(1) == t_end) begin
              core_count     <= '0;
              highest_domain <= '0;
              state          <= S_IDLE;
            end
          end
        end
        S_FAIL: begin
          result_strobe     <= 1'b1;
          result.placed_cpu <= '0;
          result.run_last   <= 1'b1;
          result.failed     <= 1'b1;
          core_count        <= '0;
          highest_domain    <= '0;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.failed |-> result.run_last)
    else $error("failure result not marked last");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.run_last |-> !busy)
    else $error("final result while placement still running");

  a_mid_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.run_last |-> busy)
    else $error("non-final result outside a run");

  a_run_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_strobe && result.run_last)
    else $error("run ended without a final result");

endmodule

>>> design/cdcp_ram.sv
// ----------------------------------------------------------------------------
// cdcp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cdcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> verif/cdcp_placement_checker.sv
// ----------------------------------------------------------------------------
// cdcp_placement_checker: result checker for cache-domain core placement
// Watches the core, configuration and result channels, keeps its own copy of
// the core list and registers, works out the CPU ids each list should place,
// and compares every result against the oldest one still owed.
// ----------------------------------------------------------------------------
module cdcp_placement_checker
  import cdcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  core_item_t            core,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  result_strobe,
  input  place_result_t         result,
  output int                    errors,
  output int                    pending,
  output int                    lists_seen,
  output int                    results_seen,
  output int                    failures_seen,
  output int                    dealt_runs,
  output int                    flat_runs
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CFG_DATA_W-1:0] parts_q;
  logic [DOM_W-1:0]      gidx_q;
  logic [CFG_DATA_W-1:0] gcnt_q;

  logic [CPU_W-1:0] list_cpu [MAX_CORES];
  logic [DOM_W-1:0] list_dom [MAX_CORES];
  int unsigned      list_len;
  logic [DOM_W-1:0] top_domain;

  place_result_t placed_q[$];
  int mismatch_n, list_n, result_n, fail_n, dealt_n, flat_n;

  // Sort the list by domain, build the placement order and queue the CPU ids.
  function automatic void plan_placement();
    int unsigned      n, gc, ndom, d, i, pos, depth, olen, offset;
    int unsigned      blen   [MAX_DOMAINS];
    int unsigned      bstart [MAX_DOMAINS];
    logic [CPU_W-1:0] sorted [MAX_CORES];
    logic [CPU_W-1:0] order  [MAX_CORES];
    bit               any, ok;
    place_result_t    r;
    n      = parts_q;
    gc     = gcnt_q;
    olen   = 0;
    offset = 0;
    ok = !(list_len == 0 || gc == 0 || n == 0 || n > RESULT_LIMIT || gc * n > list_len);
    if (ok) begin
      ndom = top_domain + 1;
      for (d = 0; d < MAX_DOMAINS; d++) blen[d] = 0;
      for (i = 0; i < list_len; i++) blen[list_dom[i]]++;
      pos = 0;
      for (d = 0; d < ndom; d++) begin
        bstart[d] = pos;
        pos += blen[d];
      end
      for (d = 0; d < MAX_DOMAINS; d++) blen[d] = 0;
      for (i = 0; i < list_len; i++) begin
        d = list_dom[i];
        sorted[bstart[d] + blen[d]] = list_cpu[i];
        blen[d]++;
      end
      if (gc <= ndom) begin
        // deal one core per chosen domain per round
        dealt_n++;
        depth = 0;
        any   = 1'b1;
        while (any) begin
          any = 1'b0;
          for (d = gidx_q; d < ndom; d += gc) begin
            if (depth < blen[d]) begin
              order[olen] = sorted[bstart[d] + depth];
              olen++;
              any = 1'b1;
            end
          end
          depth++;
        end
      end else begin
        flat_n++;
        for (i = 0; i < list_len; i++) order[i] = sorted[i];
        olen   = list_len;
        offset = gidx_q * n;
      end
      ok = (offset + n <= olen);
    end
    if (!ok) begin
      r.placed_cpu = '0;
      r.run_last   = 1'b1;
      r.failed     = 1'b1;
      placed_q = {placed_q, r};
    end else begin
      for (i = 0; i < n; i++) begin
        r.placed_cpu = order[offset + i];
        r.run_last   = (i + 1 == n);
        r.failed     = 1'b0;
        placed_q = {placed_q, r};
      end
    end
  endfunction

  always @(posedge clk) begin
    place_result_t want;
    if (rst) begin
      parts_q    = 7'd1;
      gidx_q     = '0;
      gcnt_q     = 7'd1;
      list_len   = 0;
      top_domain = '0;
      placed_q.delete();
      mismatch_n = 0;
      list_n     = 0;
      result_n   = 0;
      fail_n     = 0;
      dealt_n    = 0;
      flat_n     = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PARTITIONS:  parts_q = cfg_data;
          CFG_GROUP_INDEX: gidx_q  = cfg_data[DOM_W-1:0];
          CFG_GROUP_COUNT: gcnt_q  = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        // drop cores once the list is full; the end mark still counts
        if (list_len < MAX_CORES) begin
          list_cpu[list_len] = core.core_cpu;
          list_dom[list_len] = core.core_domain;
          list_len++;
          if (core.core_domain > top_domain) top_domain = core.core_domain;
        end
        if (core.list_end) begin
          list_n++;
          plan_placement();
          list_len   = 0;
          top_domain = '0;
        end
      end
      if (result_strobe) begin
        if (placed_q.size() == 0) begin
          mismatch_n++;
          if (mismatch_n <= 10)
            $display("unexpected result at %0t: cpu %0d last %0b failed %0b",
                     $realtime, result.placed_cpu, result.run_last, result.failed);
        end else begin
          want = placed_q.pop_front();
          result_n++;
          if (want.failed) fail_n++;
          if (result.placed_cpu !== want.placed_cpu || result.run_last !== want.run_last ||
              result.failed !== want.failed) begin
            mismatch_n++;
            if (mismatch_n <= 10)
              $display("mismatch %0t: exp cpu %0d last %0b fail %0b / got cpu %0d last %0b fail %0b",
                       $realtime, want.placed_cpu, want.run_last, want.failed,
                       result.placed_cpu, result.run_last, result.failed);
          end
        end
      end
    end
    errors        <= mismatch_n;
    pending       <= placed_q.size();
    lists_seen    <= list_n;
    results_seen  <= result_n;
    failures_seen <= fail_n;
    dealt_runs    <= dealt_n;
    flat_runs     <= flat_n;
  end

endmodule

>>> verif/tb_cache_domain_core_placement.sv
// ----------------------------------------------------------------------------
// tb_cache_domain_core_placement: stimulus and verdict for core placement
// Loads directed and random core lists under a range of register settings,
// with random gaps between transfers; the checker beside the block predicts
// and compares every placed CPU id.
// ----------------------------------------------------------------------------
module tb_cache_domain_core_placement;
  timeunit 1ns;
  timeprecision 1ps;
  import cdcp_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 440;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  core_item_t            core = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PARTITIONS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  result_strobe;
  place_result_t         result;

  int errors, pending, lists_seen, results_seen, failures_seen, dealt_runs, flat_runs;
  int quiet_cycles = 0;
  int core_transfers = 0;
  int random_items = 0;
  bit gapless = 1'b0;

  cache_domain_core_placement dut (
    .clk, .rst, .start, .busy, .core, .cfg_we, .cfg_index, .cfg_data,
    .result_strobe, .result
  );

  cdcp_placement_checker placement_chk (
    .clk, .rst, .start, .busy, .core, .cfg_we, .cfg_index, .cfg_data,
    .result_strobe, .result, .errors, .pending, .lists_seen, .results_seen,
    .failures_seen, .dealt_runs, .flat_runs
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // End the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Keep start high across back-to-back transfers; only lower it for a gap.
  task automatic send_core(input logic [CPU_W-1:0] cpu, input logic [DOM_W-1:0] dom,
                           input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      core  <= core_item_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    core  <= '{core_cpu: cpu, core_domain: dom, list_end: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    core_transfers++;
  endtask

  task automatic send_list(input int unsigned len, input int unsigned dom_hi);
    for (int unsigned i = 0; i < len; i++) begin
      send_core(CPU_W'($urandom), DOM_W'($urandom_range(0, dom_hi)), i == len - 1);
      random_items++;
    end
  endtask

  // Hold off until every owed result has come and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_config(input logic [6:0] parts, input logic [6:0] gidx,
                             input logic [6:0] gcnt);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PARTITIONS;
    cfg_data  <= parts;
    @(posedge clk);
    cfg_index <= CFG_GROUP_INDEX;
    cfg_data  <= gidx;
    @(posedge clk);
    cfg_index <= CFG_GROUP_COUNT;
    cfg_data  <= gcnt;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned phase_n, mode, n, gi, gc, span, len, dom_hi;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset registers, single core at the top of both fields.
    send_core(12'hFFF, 6'd63, 1'b1);
    load_config(7'd1, 7'd0, 7'd1);
    send_core(12'h000, 6'd0, 1'b1);
    // Dealt arm picking the odd domain only.
    load_config(7'd2, 7'd1, 7'd2);
    send_core(12'h001, 6'd0, 1'b0);
    send_core(12'h802, 6'd1, 1'b0);
    send_core(12'h003, 6'd0, 1'b0);
    send_core(12'h7FF, 6'd1, 1'b1);
    // Flat arm: more groups than domains, slice starts at the group's offset.
    load_config(7'd1, 7'd1, 7'd3);
    send_core(12'hAAA, 6'd0, 1'b0);
    send_core(12'h555, 6'd0, 1'b0);
    send_core(12'h123, 6'd0, 1'b1);
    // Flat slice running past the order.
    load_config(7'd1, 7'd5, 7'd3);
    send_core(12'h111, 6'd0, 1'b0);
    send_core(12'h222, 6'd0, 1'b0);
    send_core(12'h333, 6'd0, 1'b1);
    // Dealt arm where the chosen domain is empty.
    load_config(7'd1, 7'd1, 7'd2);
    send_core(12'h0A0, 6'd0, 1'b0);
    send_core(12'h0B0, 6'd0, 1'b0);
    send_core(12'h0C0, 6'd0, 1'b0);
    send_core(12'h0D0, 6'd2, 1'b1);
    // Register-driven failures: no groups, zero and oversized partitions, too few cores.
    load_config(7'd1, 7'd0, 7'd0);
    send_core(12'h444, 6'd3, 1'b1);
    load_config(7'd0, 7'd0, 7'd1);
    send_core(12'h445, 6'd3, 1'b1);
    load_config(7'd127, 7'd63, 7'd127);
    send_core(12'h446, 6'd3, 1'b1);
    load_config(7'd2, 7'd0, 7'd3);
    send_core(12'h447, 6'd3, 1'b1);
    // Dealing one core per domain per round over three domains.
    load_config(7'd4, 7'd0, 7'd1);
    send_core(12'h100, 6'd2, 1'b0);
    send_core(12'h200, 6'd0, 1'b0);
    send_core(12'h300, 6'd2, 1'b0);
    send_core(12'h400, 6'd0, 1'b0);
    send_core(12'h500, 6'd1, 1'b1);

    // Random phases: mostly lists sized to fit the group, a few full or overflowing.
    phase_n = 0;
    while (random_items < RANDOM_ITEMS) begin
      mode    = (phase_n == 0) ? 0 : $urandom_range(0, 15);
      gapless = ($urandom_range(0, 3) == 0);
      if (mode == 0) begin
        load_config(7'($urandom_range(32, 64)), 7'd0, 7'd1);
        send_list($urandom_range(62, 68), $urandom_range(0, 63));
      end else if (mode == 1) begin
        load_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 127)));
        repeat ($urandom_range(1, 3)) begin
          if (random_items < RANDOM_ITEMS)
            send_list($urandom_range(1, 16), $urandom_range(0, 63));
        end
      end else begin
        gc = $urandom_range(1, 4);
        n  = $urandom_range(1, 6);
        gi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                         : $urandom_range(0, gc - 1);
        load_config(7'(n), 7'(gi), 7'(gc));
        repeat ($urandom_range(2, 4)) begin
          span = gc * n;
          len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, span)
                                              : span + $urandom_range(0, span + 4);
          if (len > 48) len = 48;
          dom_hi = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 7);
          if (random_items < RANDOM_ITEMS) send_list(len, dom_hi);
        end
      end
      phase_n++;
    end

    gapless = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d cores in %0d lists, %0d random phases; %0d results, %0d failures.",
             core_transfers, lists_seen, phase_n, results_seen, failures_seen);
    $display("Placements built by dealing domains: %0d, by flat domain order: %0d.",
             dealt_runs, flat_runs);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
design/cdcp_pkg.sv
design/cdcp_ram.sv
design/cache_domain_core_placement.sv
verif/cdcp_placement_checker.sv
verif/tb_cache_domain_core_placement.sv
